FILE: rtl/core/ssdc_pkg.sv
// shared types and constants of the stepper sub-move distance check
package ssdc_pkg;

   // physical lane count and default number of active steppers
   localparam int LANES                 = 4;
   localparam int STEPPER_COUNT_DEFAULT = 4;
   localparam int LEAD_WIDTH            = $clog2(LANES);

   // field widths
   localparam int POS_WIDTH   = 32;
   localparam int STEP_WIDTH  = 8;
   localparam int LIMIT_WIDTH = 16;
   localparam int FRAC_BITS   = 8;

   // configuration register map
   localparam int CSR_INDEX_WIDTH = 1;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LOWER_LIMIT = 1'b0,
      CSR_UPPER_LIMIT = 1'b1
   } csr_index_type;

   // limit values after reset
   localparam logic [LIMIT_WIDTH-1:0] LOWER_LIMIT_RESET = 16'd128;
   localparam logic [LIMIT_WIDTH-1:0] UPPER_LIMIT_RESET = 16'd512;

   // what one lane found for one request
   typedef struct packed {
      logic [STEP_WIDTH-1:0] steps;
      logic                  negative;
      logic [POS_WIDTH-1:0]  distance;
      logic                  too_far;
   } lane_result_type;

   // one result item
   typedef struct packed {
      logic [STEP_WIDTH-1:0] steps_a;
      logic [STEP_WIDTH-1:0] steps_b;
      logic [STEP_WIDTH-1:0] steps_c;
      logic [STEP_WIDTH-1:0] steps_d;
      logic [LANES-1:0]      negative_mask;
      logic [LEAD_WIDTH-1:0] lead_stepper;
      logic [POS_WIDTH-1:0]  lead_distance;
      logic                  too_far;
      logic                  accepted;
   } rsp_payload_type;

endpackage

FILE: rtl/core/ssdc_req_if.sv
// request channel: candidate targets of the four steppers
interface ssdc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target_a;
   logic signed [31:0] target_b;
   logic signed [31:0] target_c;
   logic signed [31:0] target_d;
   logic               final_point;

   modport source (output valid, output target_a, output target_b, output target_c,
                   output target_d, output final_point, input ready);
   modport sink   (input valid, input target_a, input target_b, input target_c,
                   input target_d, input final_point, output ready);
endinterface

FILE: rtl/core/ssdc_rsp_if.sv
// response channel: step counts, lead stepper and check flags
interface ssdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  steps_a;
   logic [7:0]  steps_b;
   logic [7:0]  steps_c;
   logic [7:0]  steps_d;
   logic [3:0]  negative_mask;
   logic [1:0]  lead_stepper;
   logic [31:0] lead_distance;
   logic        too_far;
   logic        accepted;

   modport source (output valid, output steps_a, output steps_b, output steps_c,
                   output steps_d, output negative_mask, output lead_stepper,
                   output lead_distance, output too_far, output accepted, input ready);
   modport sink   (input valid, input steps_a, input steps_b, input steps_c,
                   input steps_d, input negative_mask, input lead_stepper,
                   input lead_distance, input too_far, input accepted, output ready);
endinterface

FILE: rtl/core/stepper_submove_distance_check_unit.sv
// top level of the stepper sub-move distance check
//
//  channel | direction | handshake          | contents
//  req_bus | in        | valid/ready        | four Q24.8 targets, final point flag
//  rsp_bus | out       | valid/ready        | step counts, mask, lead, flags
//  csr_*   | in        | write enable only  | lower and upper limit registers
//
// one request per cycle sustained while rsp_bus.ready holds; a request passes through the
// lane stage register, then the merge stage response register, before its response appears
// synchronous active-high reset clears positions and the valid bits and loads the reset limits
// the stages advance as a pipeline: a stalled response blocks only when both
// stages hold data, and req_bus.ready follows rsp_bus.ready in the same cycle
module stepper_submove_distance_check_unit #(
   parameter int STEPPER_COUNT = ssdc_pkg::STEPPER_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ssdc_req_if.sink                             req_bus,
   ssdc_rsp_if.source                           rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [ssdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ssdc_pkg::LIMIT_WIDTH-1:0]     csr_write_data
);
   import ssdc_pkg::*;

   logic                   lane_valid_ff;
   logic                   rsp_valid_ff;
   logic                   lane_final_ff;
   logic [LIMIT_WIDTH-1:0] lower_limit_ff;
   logic [LIMIT_WIDTH-1:0] upper_limit_ff;
   logic                   req_accept;
   logic                   merge_load;
   logic signed [POS_WIDTH-1:0] targets [LANES];
   lane_result_type        lane_results [LANES];
   rsp_payload_type        payload;

   // pipeline advance
   assign merge_load    = lane_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !lane_valid_ff || merge_load;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_limit_ff <= LOWER_LIMIT_RESET;
         upper_limit_ff <= UPPER_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOWER_LIMIT: lower_limit_ff <= csr_write_data;
            CSR_UPPER_LIMIT: upper_limit_ff <= csr_write_data;
         endcase
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            lane_valid_ff <= req_bus.valid;
         end
         if (!rsp_valid_ff || rsp_bus.ready) begin
            rsp_valid_ff <= lane_valid_ff;
         end
      end
   end

   // final point flag travels beside the lane results
   always_ff @(posedge clock) begin
      if (req_accept) begin
         lane_final_ff <= req_bus.final_point;
      end
   end

   assign targets[0] = req_bus.target_a;
   assign targets[1] = req_bus.target_b;
   assign targets[2] = req_bus.target_c;
   assign targets[3] = req_bus.target_d;

   // stepper lanes, unused ones read as standing still
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      if (g < STEPPER_COUNT) begin : g_active
         ssdc_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .accept      (req_accept),
            .target      (targets[g]),
            .upper_limit (upper_limit_ff),
            .result      (lane_results[g])
         );
      end else begin : g_idle
         assign lane_results[g] = '0;
      end
   end

   ssdc_merge u_merge (
      .clock        (clock),
      .load         (merge_load),
      .lane_results (lane_results),
      .final_point  (lane_final_ff),
      .lower_limit  (lower_limit_ff),
      .payload      (payload)
   );

   // response channel
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.steps_a       = payload.steps_a;
   assign rsp_bus.steps_b       = payload.steps_b;
   assign rsp_bus.steps_c       = payload.steps_c;
   assign rsp_bus.steps_d       = payload.steps_d;
   assign rsp_bus.negative_mask = payload.negative_mask;
   assign rsp_bus.lead_stepper  = payload.lead_stepper;
   assign rsp_bus.lead_distance = payload.lead_distance;
   assign rsp_bus.too_far       = payload.too_far;
   assign rsp_bus.accepted      = payload.accepted;

   // an accepted request always lands in the lane stage
   a_accept_fills_lane: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> lane_valid_ff)
      else $error("accepted request not held in lane stage");

   // a blocked lane stage keeps its item
   a_lane_holds: assert property (@(posedge clock) disable iff (reset)
      (lane_valid_ff && !merge_load) |=> (lane_valid_ff && $stable(lane_final_ff)))
      else $error("lane stage lost its item while stalled");

   // no lead stepper other than the first when nothing moves
   a_lead_without_move: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (payload.lead_distance == '0)) |-> (payload.lead_stepper == '0))
      else $error("lead stepper set without distance");

   // unused lanes never report a negative move
   a_idle_lane_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((payload.negative_mask >> STEPPER_COUNT) == '0))
      else $error("negative mask set on an unused lane");

endmodule

FILE: rtl/core/ssdc_lane.sv
// one stepper lane: current position and registered distance of the request
module ssdc_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic signed [ssdc_pkg::POS_WIDTH-1:0]   target,
   input  logic [ssdc_pkg::LIMIT_WIDTH-1:0]    upper_limit,
   output ssdc_pkg::lane_result_type           result
);
   import ssdc_pkg::*;

   logic [POS_WIDTH-1:0]  position_ff;
   lane_result_type       result_ff;
   lane_result_type       result_in;
   logic [POS_WIDTH:0]    diff;
   logic [POS_WIDTH:0]    mag;
   logic [STEP_WIDTH-1:0] whole_fwd;

   // signed difference, magnitude and wrapped whole-step count
   always_comb begin
      diff      = {target[POS_WIDTH-1], target} - {position_ff[POS_WIDTH-1], position_ff};
      mag       = diff[POS_WIDTH] ? (~diff + 1'b1) : diff;
      whole_fwd = target[FRAC_BITS +: STEP_WIDTH] - position_ff[FRAC_BITS +: STEP_WIDTH];
      result_in.negative = diff[POS_WIDTH];
      result_in.steps    = diff[POS_WIDTH] ? (~whole_fwd + 1'b1) : whole_fwd;
      result_in.distance = mag[POS_WIDTH] ? '1 : mag[POS_WIDTH-1:0];
      result_in.too_far  = (mag >= {{(POS_WIDTH + 1 - LIMIT_WIDTH){1'b0}}, upper_limit});
   end

   // position always takes the candidate target
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else if (accept) begin
         position_ff <= target;
      end
   end

   // lane result register
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: rtl/core/ssdc_merge.sv
// merging stage: lead stepper selection, limit checks and response register
module ssdc_merge (
   input  logic                                  clock,
   input  logic                                  load,
   input  ssdc_pkg::lane_result_type             lane_results [ssdc_pkg::LANES],
   input  logic                                  final_point,
   input  logic [ssdc_pkg::LIMIT_WIDTH-1:0]      lower_limit,
   output ssdc_pkg::rsp_payload_type             payload
);
   import ssdc_pkg::*;

   rsp_payload_type       payload_ff;
   rsp_payload_type       payload_in;
   logic [STEP_WIDTH-1:0] best_steps;
   logic [LEAD_WIDTH-1:0] lead;
   logic [POS_WIDTH-1:0]  lead_dist;
   logic                  far;
   logic [LANES-1:0]      neg_mask;

   // first lane with the strictly largest step count leads
   always_comb begin
      best_steps = '0;
      lead       = '0;
      lead_dist  = '0;
      far        = 1'b0;
      neg_mask   = '0;
      for (int i = 0; i < LANES; i++) begin
         neg_mask[i] = lane_results[i].negative;
         far         = far | lane_results[i].too_far;
         if (lane_results[i].steps > best_steps) begin
            best_steps = lane_results[i].steps;
            lead       = LEAD_WIDTH'(i);
            lead_dist  = lane_results[i].distance;
         end
      end
      payload_in.steps_a       = lane_results[0].steps;
      payload_in.steps_b       = lane_results[1].steps;
      payload_in.steps_c       = lane_results[2].steps;
      payload_in.steps_d       = lane_results[3].steps;
      payload_in.negative_mask = neg_mask;
      payload_in.lead_stepper  = lead;
      payload_in.lead_distance = lead_dist;
      payload_in.too_far       = far;
      payload_in.accepted      = final_point ||
         (!far && (lead_dist > {{(POS_WIDTH - LIMIT_WIDTH){1'b0}}, lower_limit}));
   end

   // response register
   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= payload_in;
      end
   end

   assign payload = payload_ff;

endmodule

FILE: dv/stepper_submove_distance_check_unit_tb.sv
// testbench of the stepper sub-move distance check: directed and random candidates, scored
`timescale 1ns / 1ps

module stepper_submove_distance_check_unit_tb;
   import ssdc_pkg::*;

   localparam int STEPPERS      = STEPPER_COUNT_DEFAULT;
   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 250;

   // one candidate request as the sender builds it
   typedef struct {
      logic signed [POS_WIDTH-1:0] target [LANES];
      logic                        final_point;
   } candidate_type;

   // predicted step counts and limit checks, compared with what the block returns
   class submove_scoreboard;
      logic signed [POS_WIDTH-1:0] position [LANES];
      logic [LIMIT_WIDTH-1:0]      lower_limit;
      logic [LIMIT_WIDTH-1:0]      upper_limit;
      rsp_payload_type             expected_moves [$];
      int                          mismatches;

      function void clear();
         foreach (position[i]) position[i] = '0;
         lower_limit = LOWER_LIMIT_RESET;
         upper_limit = UPPER_LIMIT_RESET;
         expected_moves.delete();
         mismatches = 0;
      endfunction

      function void set_limit(csr_index_type idx, logic [LIMIT_WIDTH-1:0] value);
         if (idx == CSR_LOWER_LIMIT) lower_limit = value;
         else if (idx == CSR_UPPER_LIMIT) upper_limit = value;
      endfunction

      function int pending();
         return expected_moves.size();
      endfunction

      // step counts, lead stepper and flags of one candidate; positions always follow
      function rsp_payload_type predict_submove(candidate_type c);
         rsp_payload_type    r;
         logic signed [63:0] tgt, cur, diff, whole;
         logic [63:0]        mag;
         logic [7:0]         steps [LANES];
         logic [7:0]         best;
         logic [3:0]         neg;
         logic [1:0]         lead;
         logic [31:0]        lead_dist;
         logic               far;
         best      = '0;
         neg       = '0;
         lead      = '0;
         lead_dist = '0;
         far       = 1'b0;
         foreach (steps[i]) steps[i] = '0;
         for (int i = 0; i < STEPPERS; i++) begin
            tgt  = 64'(c.target[i]);
            cur  = 64'(position[i]);
            diff = tgt - cur;
            position[i] = c.target[i];
            // arithmetic shift by the fraction bits is the floor of the step count
            if (diff < 0) begin
               mag    = -diff;
               neg[i] = 1'b1;
               whole  = (cur >>> FRAC_BITS) - (tgt >>> FRAC_BITS);
            end else begin
               mag   = diff;
               whole = (tgt >>> FRAC_BITS) - (cur >>> FRAC_BITS);
            end
            steps[i] = whole[7:0];
            if (mag >= {48'd0, upper_limit}) far = 1'b1;
            // lead goes by the wrapped step count, first stepper wins a tie
            if (steps[i] > best) begin
               best      = steps[i];
               lead      = i[1:0];
               lead_dist = (mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
            end
         end
         r.steps_a       = steps[0];
         r.steps_b       = steps[1];
         r.steps_c       = steps[2];
         r.steps_d       = steps[3];
         r.negative_mask = neg;
         r.lead_stepper  = lead;
         r.lead_distance = lead_dist;
         r.too_far       = far;
         r.accepted      = c.final_point || (!far && lead_dist > {16'd0, lower_limit});
         return r;
      endfunction

      function void note_request(candidate_type c);
         expected_moves.push_back(predict_submove(c));
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t mismatch on %s: expected %h actual %h", $realtime, field, want, got);
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_moves.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t response with nothing expected", $realtime);
            return;
         end
         want = expected_moves.pop_front();
         compare_field("steps_a", 32'(want.steps_a), 32'(got.steps_a));
         compare_field("steps_b", 32'(want.steps_b), 32'(got.steps_b));
         compare_field("steps_c", 32'(want.steps_c), 32'(got.steps_c));
         compare_field("steps_d", 32'(want.steps_d), 32'(got.steps_d));
         compare_field("negative_mask", 32'(want.negative_mask), 32'(got.negative_mask));
         compare_field("lead_stepper", 32'(want.lead_stepper), 32'(got.lead_stepper));
         compare_field("lead_distance", want.lead_distance, got.lead_distance);
         compare_field("too_far", 32'(want.too_far), 32'(got.too_far));
         compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [LIMIT_WIDTH-1:0]     csr_write_data;

   ssdc_req_if req_bus ();
   ssdc_rsp_if rsp_bus ();

   submove_scoreboard board = new();

   logic signed [POS_WIDTH-1:0] last_target [LANES];
   bit sender_steady;
   bit receiver_steady;
   int idle_cycles;

   stepper_submove_distance_check_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // next random candidate: mostly small moves from the last targets
   function automatic candidate_type random_candidate();
      candidate_type c;
      int            r;
      bit            hold_all;
      hold_all = ($urandom_range(0, 19) == 0);
      for (int i = 0; i < LANES; i++) begin
         r = $urandom_range(0, 99);
         if (hold_all || r >= 90)
            c.target[i] = last_target[i];
         else if (r < 60)
            c.target[i] = last_target[i] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1)
                          * $signed({22'd0, 10'($urandom_range(0, 1023))});
         else if (r < 80)
            c.target[i] = last_target[i] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1)
                          * $signed({14'd0, 18'($urandom_range(0, 18'h3FFFF))});
         else
            c.target[i] = $urandom;
         last_target[i] = c.target[i];
      end
      c.final_point = ($urandom_range(0, 7) == 0);
      return c;
   endfunction

   // send one request; called and returns at a falling edge
   task automatic push_request(input candidate_type c);
      int gap;
      gap = pick_gap(sender_steady);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.target_a    = c.target[0];
      req_bus.target_b    = c.target[1];
      req_bus.target_c    = c.target[2];
      req_bus.target_d    = c.target[3];
      req_bus.final_point = c.final_point;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(c);
      @(negedge clock);
   endtask

   task automatic send_targets(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d, input logic fin);
      candidate_type cand;
      cand.target[0]   = a;
      cand.target[1]   = b;
      cand.target[2]   = c;
      cand.target[3]   = d;
      cand.final_point = fin;
      foreach (last_target[i]) last_target[i] = cand.target[i];
      push_request(cand);
   endtask

   // stop sending and wait until every response is back
   task automatic wait_drain();
      req_bus.valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input csr_index_type idx, input logic [LIMIT_WIDTH-1:0] value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(posedge clock);
      board.set_limit(idx, value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // response side: random stalls on ready
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else begin
            rsp_bus.ready = 1'b1;
            stall = pick_gap(receiver_steady);
         end
      end
   end

   // score every accepted response
   always @(posedge clock) begin
      rsp_payload_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.steps_a       = rsp_bus.steps_a;
         got.steps_b       = rsp_bus.steps_b;
         got.steps_c       = rsp_bus.steps_c;
         got.steps_d       = rsp_bus.steps_d;
         got.negative_mask = rsp_bus.negative_mask;
         got.lead_stepper  = rsp_bus.lead_stepper;
         got.lead_distance = rsp_bus.lead_distance;
         got.too_far       = rsp_bus.too_far;
         got.accepted      = rsp_bus.accepted;
         board.check_result(got);
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // reset, directed requests, then random phases under several limit settings
   initial begin
      logic [LIMIT_WIDTH-1:0] lower_set [PHASES];
      logic [LIMIT_WIDTH-1:0] upper_set [PHASES];
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_LOWER_LIMIT;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.target_a    = '0;
      req_bus.target_b    = '0;
      req_bus.target_c    = '0;
      req_bus.target_d    = '0;
      req_bus.final_point = 1'b0;
      sender_steady       = 1'b0;
      receiver_steady     = 1'b0;
      foreach (last_target[i]) last_target[i] = '0;
      board.clear();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed part under reset limits
      send_targets(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);                 // nothing moves
      send_targets(32'h100, -32'sd256, 32'h80, 32'h0, 1'b0);          // tie on one step
      send_targets(32'h1FF, -32'sd384, 32'h100, 32'h0, 1'b0);         // fraction crosses step
      send_targets(32'h101FF, -32'sd1664, 32'h100, 32'h0, 1'b0);      // wrapped step count
      send_targets(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFF00, 1'b1);
      send_targets(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h1, 1'b0);   // full-range swing
      send_targets(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h1, 1'b1);   // final, nothing moves
      send_targets(32'h80000200, 32'h7FFFFE00, 32'h200, 32'h201, 1'b0);
      send_targets(32'h80000200, 32'h7FFFFE00, 32'h180, 32'h101, 1'b0);
      send_targets(32'h80000200, 32'h7FFFFE00, 32'h380, 32'h101, 1'b0);
      send_targets(32'h80000200, 32'h7FFFFE00, 32'h380, 32'h281, 1'b0);
      send_targets(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
      send_targets(32'hFFFFFF01, 32'hFFFFFF00, 32'hFFFFFE01, 32'h55555555, 1'b0);
      send_targets(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 1'b0);
      wait_drain();

      // limit settings, extremes first
      lower_set[0] = 16'd0;     upper_set[0] = 16'd0;
      lower_set[1] = 16'hFFFF;  upper_set[1] = 16'hFFFF;
      lower_set[2] = 16'd0;     upper_set[2] = 16'hFFFF;
      lower_set[3] = 16'hFFFF;  upper_set[3] = 16'd0;
      lower_set[4] = 16'd256;   upper_set[4] = 16'd1024;
      lower_set[5] = 16'($urandom_range(0, 65535));
      upper_set[5] = 16'($urandom_range(0, 65535));

      for (int ph = 0; ph < PHASES; ph++) begin
         sender_steady   = (ph == 2);
         receiver_steady = (ph == 2 || ph == 4);
         write_limit(CSR_LOWER_LIMIT, lower_set[ph]);
         write_limit(CSR_UPPER_LIMIT, upper_set[ph]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // sender holds off mid-phase until the pipeline is empty
            if (k == PHASE_ITEMS / 2) wait_drain();
            push_request(random_candidate());
         end
         wait_drain();
      end

      // final verdict
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
